>>> hdl/bgcs_pkg.sv
// Package for the button gesture color selector.
// Holds field widths, register reset values, register indexes, the item and
// result types and the step constants of the index reduction. Depends on nothing.
package bgcs_pkg;

  localparam int unsigned TsW    = 32;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimeW-1:0] DebounceRst = 16'd50;
  localparam logic [TimeW-1:0] LongPressRst = 16'd3000;
  localparam logic [TimeW-1:0] DblWindowRst = 16'd400;
  localparam logic [IdxW-1:0]  ColorCountRst = 8'd8;

  // Index value one; also the successor of index zero for counts of two and up.
  localparam logic [IdxW-1:0]  IdxOne = 8'd1;

  // The index reduction runs one restoring step per cycle, from shift IdxW
  // down to zero, so a count of one can take a quotient of 256.
  localparam int unsigned      StepW     = 4;
  localparam logic [StepW-1:0] StepFirst = StepW'(IdxW);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE    = 8'd0,
    CFG_LONG_PRESS  = 8'd1,
    CFG_DBL_WINDOW  = 8'd2,
    CFG_COLOR_COUNT = 8'd3
  } cfg_idx_t;

  // One input item.
  typedef struct packed {
    logic [TsW-1:0] timestamp;
    logic           pressed;
  } bgcs_item_t;

  // One result item.
  typedef struct packed {
    logic            calibrate_request;
    logic            color_saved;
    logic            color_shown;
    logic [IdxW-1:0] color_index;
    logic            select_mode;
  } bgcs_result_t;

endpackage

>>> hdl/bgcs_in_stage.sv
// Input register of the button gesture color selector.
// Holds one accepted item until the gesture core takes it. Uses bgcs_pkg.
module bgcs_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_timestamp,
  input  logic               in_pressed,
  input  logic               take,
  output logic               item_valid,
  output bgcs_pkg::bgcs_item_t item
);
  import bgcs_pkg::*;

  logic       valid_r;
  bgcs_item_t item_r;

  // The register frees up in the same cycle that the core takes its item.
  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.timestamp <= in_timestamp;
      item_r.pressed   <= in_pressed;
    end
  end

endmodule

>>> hdl/bgcs_core.sv
// Gesture core of the button gesture color selector.
// Holds the configuration registers and the gesture state, and decodes one
// item per cycle, while fire is high, into a result. Uses bgcs_pkg.
module bgcs_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  fire,
  output logic                  busy,
  input  bgcs_pkg::bgcs_item_t  item,
  output bgcs_pkg::bgcs_result_t res
);
  import bgcs_pkg::*;

  // Configuration registers.
  logic [TimeW-1:0] debounce_r;
  logic [TimeW-1:0] long_press_r;
  logic [TimeW-1:0] dbl_window_r;
  logic [IdxW-1:0]  color_count_r;

  // Gesture state.
  logic            prev_level_r, prev_level_nxt;
  logic [TsW-1:0]  press_start_r, press_start_nxt;
  logic [TsW-1:0]  last_edge_r, last_edge_nxt;
  logic            mode_r, mode_nxt;
  logic [IdxW-1:0] sel_index_r, sel_index_nxt;
  logic            cal_latched_r, cal_latched_nxt;

  // Successor of the color index, (sel_index + 1) mod count, and the
  // multi-cycle reduction that rebuilds it after a count write.
  logic [IdxW-1:0]    succ_r, succ_nxt;
  logic [IdxW-1:0]    succ_inc;
  logic               busy_r;
  logic [IdxW:0]      rem_r, rem_nxt;
  logic [StepW-1:0]   step_r;
  logic [2*IdxW:0]    step_sub;
  logic [IdxW-1:0]    idx_after;
  logic               cnt_write;

  logic [TsW-1:0] since_edge;
  logic [TsW-1:0] held;
  logic           cal;
  logic           edge_ok;
  logic           dbl;
  logic           saved;
  logic           shown;

  assign cfg_ready = !busy_r;
  assign busy      = busy_r;
  assign cnt_write = cfg_valid && cfg_ready && (cfg_index == CFG_COLOR_COUNT);
  assign idx_after = fire ? sel_index_nxt : sel_index_r;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DebounceRst;
      long_press_r  <= LongPressRst;
      dbl_window_r  <= DblWindowRst;
      color_count_r <= ColorCountRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE:    debounce_r    <= cfg_data;
        CFG_LONG_PRESS:  long_press_r  <= cfg_data;
        CFG_DBL_WINDOW:  dbl_window_r  <= cfg_data;
        CFG_COLOR_COUNT: color_count_r <= cfg_data[IdxW-1:0];
        default: ;
      endcase
    end
  end

  // Gesture decode. Time differences wrap modulo 2^32.
  always_comb begin
    since_edge = item.timestamp - last_edge_r;
    held       = item.timestamp - press_start_r;
    cal = item.pressed && prev_level_r && !mode_r && !cal_latched_r &&
          (held >= {{(TsW-TimeW){1'b0}}, long_press_r});
    edge_ok = (item.pressed != prev_level_r) &&
              (since_edge > {{(TsW-TimeW){1'b0}}, debounce_r});
    dbl   = since_edge < {{(TsW-TimeW){1'b0}}, dbl_window_r};
    saved = 1'b0;
    shown = 1'b0;
    succ_inc = succ_r + IdxOne;

    prev_level_nxt  = item.pressed;
    press_start_nxt = press_start_r;
    last_edge_nxt   = last_edge_r;
    mode_nxt        = mode_r;
    sel_index_nxt   = sel_index_r;
    cal_latched_nxt = cal_latched_r || cal;
    succ_nxt        = succ_r;

    if (edge_ok) begin
      last_edge_nxt = item.timestamp;
      if (item.pressed) begin
        press_start_nxt = item.timestamp;
        if (dbl) begin
          if (mode_r) begin
            saved    = 1'b1;
            mode_nxt = 1'b0;
          end else begin
            mode_nxt      = 1'b1;
            sel_index_nxt = '0;
            succ_nxt      = (color_count_r == IdxOne) ? '0 : IdxOne;
          end
        end
      end else if (mode_r) begin
        // The successor is already reduced, so the next one only wraps at
        // the count; a count of zero wraps with the 8-bit increment.
        sel_index_nxt   = succ_r;
        succ_nxt        = (succ_inc == color_count_r) ? '0 : succ_inc;
        shown           = 1'b1;
        cal_latched_nxt = 1'b0;
      end
    end

    res.calibrate_request = cal;
    res.color_saved       = saved;
    res.color_shown       = shown;
    res.color_index       = sel_index_nxt;
    res.select_mode       = mode_nxt;
  end

  // One restoring compare-and-subtract step of the index reduction.
  always_comb begin
    step_sub = {{(IdxW+1){1'b0}}, color_count_r} << step_r;
    if ({{IdxW{1'b0}}, rem_r} >= step_sub) begin
      rem_nxt = rem_r - step_sub[IdxW:0];
    end else begin
      rem_nxt = rem_r;
    end
  end

  // Index reduction sequencer; items and writes wait while it runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cnt_write) begin
      busy_r <= 1'b1;
      rem_r  <= {1'b0, idx_after} + {{IdxW{1'b0}}, 1'b1};
      step_r <= StepFirst;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      if (step_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r - {{(StepW-1){1'b0}}, 1'b1};
      end
    end
  end

  // Successor register; the reset count of eight gives a successor of one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      succ_r <= IdxOne;
    end else if (busy_r && step_r == '0) begin
      succ_r <= rem_nxt[IdxW-1:0];
    end else if (fire) begin
      succ_r <= succ_nxt;
    end
  end

  // State update, one item per cycle while fire is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b0;
      press_start_r <= '0;
      last_edge_r   <= '0;
      mode_r        <= 1'b0;
      sel_index_r   <= '0;
      cal_latched_r <= 1'b0;
    end else if (fire) begin
      prev_level_r  <= prev_level_nxt;
      press_start_r <= press_start_nxt;
      last_edge_r   <= last_edge_nxt;
      mode_r        <= mode_nxt;
      sel_index_r   <= sel_index_nxt;
      cal_latched_r <= cal_latched_nxt;
    end
  end

`ifndef SYNTHESIS
  // A save always leaves select mode.
  a_save_leaves_mode: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.color_saved |=> !mode_r)
    else $error("select mode still active after a save");

  // A calibration request sets the latch.
  a_cal_latches: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.calibrate_request |=> cal_latched_r)
    else $error("calibration latch not set after a request");

  // A shown color comes only from select mode, which the release keeps.
  a_shown_in_mode: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.color_shown |-> mode_r && res.select_mode)
    else $error("color shown outside select mode");

  // Without an item the gesture state holds.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(sel_index_r) && $stable(mode_r) && $stable(last_edge_r))
    else $error("gesture state changed without an item");

  // No item is decoded while the index reduction runs.
  a_no_item_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !fire)
    else $error("item decoded during the index reduction");
`endif

endmodule

>>> hdl/bgcs_out_stage.sv
// Output register of the button gesture color selector.
// Holds one result item until the consumer takes it. Uses bgcs_pkg.
module bgcs_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  bgcs_pkg::bgcs_result_t res,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_calibrate_request,
  output logic                   out_color_saved,
  output logic                   out_color_shown,
  output logic [7:0]             out_color_index,
  output logic                   out_select_mode
);
  import bgcs_pkg::*;

  logic         valid_r;
  bgcs_result_t res_r;

  // A new result may enter when the register is empty or being drained.
  assign space = !valid_r || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_valid             = valid_r;
  assign out_calibrate_request = res_r.calibrate_request;
  assign out_color_saved       = res_r.color_saved;
  assign out_color_shown       = res_r.color_shown;
  assign out_color_index       = res_r.color_index;
  assign out_select_mode       = res_r.select_mode;

endmodule

>>> hdl/button_gesture_color_selector_unit.sv
// Top level of the button gesture color selector.
// Joins the input register, the gesture core and the output register.
// Uses bgcs_pkg, bgcs_in_stage, bgcs_core and bgcs_out_stage.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   timestamp[31:0], pressed
//   out_     output     out_valid / out_ready calibrate_request, color_saved,
//                                             color_shown, color_index[7:0],
//                                             select_mode
//   cfg_     input      cfg_valid / cfg_ready index[7:0], data[15:0]
//
// One item per cycle sustained unless the output stalls or a reduction runs;
// out_valid rises once an accepted item passes the input register and then the
// gesture decode into the output register. A color count write starts the index
// reduction; items wait in the input register and cfg_ready stays low until it ends.
// Reset is synchronous on rst_n low and restores the register defaults.
// A stalled output holds one result and still lets the input register fill.
module button_gesture_color_selector_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_timestamp,
  input  logic        in_pressed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_calibrate_request,
  output logic        out_color_saved,
  output logic        out_color_shown,
  output logic [7:0]  out_color_index,
  output logic        out_select_mode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bgcs_pkg::*;

  logic         item_valid;
  bgcs_item_t   item;
  bgcs_result_t res;
  logic         space;
  logic         busy;
  logic         fire;

  // An item moves through the core when the output register can take it
  // and no index reduction is running.
  assign fire = item_valid && space && !busy;

  bgcs_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_timestamp (in_timestamp),
    .in_pressed   (in_pressed),
    .take         (fire),
    .item_valid   (item_valid),
    .item         (item)
  );

  bgcs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .busy      (busy),
    .item      (item),
    .res       (res)
  );

  bgcs_out_stage u_out (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (fire),
    .res                   (res),
    .space                 (space),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_calibrate_request (out_calibrate_request),
    .out_color_saved       (out_color_saved),
    .out_color_shown       (out_color_shown),
    .out_color_index       (out_color_index),
    .out_select_mode       (out_select_mode)
  );

endmodule

>>> sim/tb_button_gesture_color_selector_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_gesture_color_selector_unit.
// Predicts every result from its own gesture decoder and compares field by field.
// Depends on bgcs_pkg and the RTL of the unit under test.
module tb_button_gesture_color_selector_unit;
  import bgcs_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam logic [CfgIdxW-1:0] UnusedRegLow  = 8'd4;
  localparam logic [CfgIdxW-1:0] UnusedRegHigh = 8'hFF;

  // Clock, reset and ports of the unit under test.
  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [TsW-1:0]    in_timestamp = '0;
  logic              in_pressed   = 1'b0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic              out_calibrate_request;
  logic              out_color_saved;
  logic              out_color_shown;
  logic [IdxW-1:0]   out_color_index;
  logic              out_select_mode;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  // Shadow copy of the configuration registers.
  logic [TimeW-1:0] debounce_ticks   = DebounceRst;
  logic [TimeW-1:0] long_press_ticks = LongPressRst;
  logic [TimeW-1:0] dbl_window_ticks = DblWindowRst;
  logic [IdxW-1:0]  color_total      = ColorCountRst;

  // Gesture state as the decoder sees it.
  logic             btn_prev_level = 1'b0;
  logic [TsW-1:0]   press_start_ts = '0;
  logic [TsW-1:0]   last_edge_ts   = '0;
  logic             in_select      = 1'b0;
  logic [IdxW-1:0]  sel_idx        = '0;
  logic             cal_held       = 1'b0;

  bgcs_result_t     gesture_results_due[$];
  bgcs_result_t     head_result;
  logic [TsW-1:0]   now_ts       = '0;
  bit               idle_on      = 1'b1;
  int unsigned      stall_left   = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      items_sent   = 0;
  int unsigned      results_checked = 0;
  int unsigned      cal_count    = 0;
  int unsigned      saved_count  = 0;
  int unsigned      shown_count  = 0;
  int unsigned      cfg_writes   = 0;
  int unsigned      error_count  = 0;

  button_gesture_color_selector_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_timestamp          (in_timestamp),
    .in_pressed            (in_pressed),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_calibrate_request (out_calibrate_request),
    .out_color_saved       (out_color_saved),
    .out_color_shown       (out_color_shown),
    .out_color_index       (out_color_index),
    .out_select_mode       (out_select_mode),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the result of one accepted sample and advances the gesture state.
  task automatic decode_gesture(input logic [TsW-1:0] ts, input logic level);
    logic [TsW-1:0] since_edge;
    logic [TsW-1:0] held_ticks;
    logic [IdxW:0]  wrap_at;
    bgcs_result_t   res;
    res        = '0;
    since_edge = ts - last_edge_ts;
    held_ticks = ts - press_start_ts;
    // A long hold raises the calibration request once, before edge handling.
    if (level && btn_prev_level && !in_select && !cal_held &&
        held_ticks >= TsW'(long_press_ticks)) begin
      res.calibrate_request = 1'b1;
      cal_held = 1'b1;
    end
    // Only edges outside the debounce time count.
    if (level != btn_prev_level && since_edge > TsW'(debounce_ticks)) begin
      if (level) begin
        if (since_edge < TsW'(dbl_window_ticks)) begin
          if (in_select) begin
            res.color_saved = 1'b1;
            in_select = 1'b0;
          end else begin
            in_select = 1'b1;
            sel_idx   = '0;
          end
        end
        press_start_ts = ts;
      end else if (in_select) begin
        wrap_at = (color_total == '0) ? 9'd256 : {1'b0, color_total};
        sel_idx = IdxW'(({1'b0, sel_idx} + 9'd1) % wrap_at);
        res.color_shown = 1'b1;
        cal_held = 1'b0;
      end
      last_edge_ts = ts;
    end
    btn_prev_level    = level;
    res.color_index   = sel_idx;
    res.select_mode   = in_select;
    gesture_results_due.push_back(res);
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("ERROR at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Sends one sample item, with an occasional idle burst in front of it.
  task automatic send_sample(input logic [TsW-1:0] ts, input logic level);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    now_ts       = ts;
    in_valid     <= 1'b1;
    in_timestamp <= ts;
    in_pressed   <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    decode_gesture(ts, level);
  endtask

  task automatic sample_after(input logic [TsW-1:0] delta, input logic level);
    send_sample(now_ts + delta, level);
  endtask

  // Holds off the sender until every predicted result has been checked.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (gesture_results_due.size() != 0) @(posedge clk);
  endtask

  // Writes one register once the unit is idle and updates the shadow copy.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      CFG_DEBOUNCE:    debounce_ticks   = data;
      CFG_LONG_PRESS:  long_press_ticks = data;
      CFG_DBL_WINDOW:  dbl_window_ticks = data;
      CFG_COLOR_COUNT: color_total      = data[IdxW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int unsigned deb, input int unsigned hold,
                              input int unsigned win, input int unsigned cnt);
    write_reg(CFG_DEBOUNCE, CfgDataW'(deb));
    write_reg(CFG_LONG_PRESS, CfgDataW'(hold));
    write_reg(CFG_DBL_WINDOW, CfgDataW'(win));
    write_reg(CFG_COLOR_COUNT, CfgDataW'(cnt));
  endtask

  // Gaps measured against the current timing registers.
  function automatic logic [TsW-1:0] past_debounce();
    return TsW'(debounce_ticks) + 32'd1 + TsW'($urandom_range(0, 20));
  endfunction

  function automatic logic [TsW-1:0] within_debounce();
    return TsW'($urandom_range(0, int'(debounce_ticks)));
  endfunction

  function automatic logic [TsW-1:0] second_press_gap();
    if (int'(dbl_window_ticks) > int'(debounce_ticks) + 1) begin
      return TsW'($urandom_range(int'(debounce_ticks) + 1, int'(dbl_window_ticks) - 1));
    end
    return past_debounce();
  endfunction

  // Toggles into select mode with quick press pairs; needs a wide window.
  task automatic enter_select_mode();
    while (!in_select) begin
      sample_after(32'd1, 1'b0);
      sample_after(32'd1, 1'b1);
    end
  endtask

  // One random gesture: mostly well-formed, sometimes bounce or noise.
  task automatic random_gesture();
    logic [TsW-1:0] span;
    int             kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        // Single click, sometimes with a held sample in between.
        sample_after(past_debounce(), 1'b1);
        if ($urandom_range(0, 1) == 1) begin
          sample_after(within_debounce(), 1'b1);
        end
        sample_after(past_debounce(), 1'b0);
      end
      3, 4: begin
        // Double click.
        sample_after(past_debounce(), 1'b1);
        sample_after(past_debounce(), 1'b0);
        sample_after(second_press_gap(), 1'b1);
        sample_after(past_debounce(), 1'b0);
      end
      5: begin
        // Long press ending just short of, at, or past the hold time.
        sample_after(past_debounce(), 1'b1);
        span = TsW'(long_press_ticks) + TsW'($urandom_range(0, 2));
        if (span != 0) begin
          span = span - 32'd1;
        end
        sample_after(span / 2, 1'b1);
        sample_after(span - span / 2, 1'b1);
        sample_after(past_debounce(), 1'b0);
      end
      6: begin
        // Contact bounce inside the debounce time.
        repeat ($urandom_range(2, 4)) begin
          sample_after(within_debounce(), 1'($urandom_range(0, 1)));
        end
      end
      7: begin
        // Noise: any timestamp, any level.
        send_sample($urandom, 1'($urandom_range(0, 1)));
      end
      8: begin
        // Click that straddles the timestamp wrap.
        now_ts = 32'hFFFF_FFFF - TsW'($urandom_range(0, int'(debounce_ticks) + 40));
        sample_after(past_debounce(), 1'b1);
        sample_after(past_debounce(), 1'b0);
      end
      default: begin
        // Level unchanged after a long quiet spell.
        sample_after(TsW'($urandom_range(0, 70000)), btn_prev_level);
      end
    endcase
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) random_gesture();
  endtask

  // Reset values: debounce, release outside the mode, long press and its latch,
  // double click in and out of select mode, and index advance on release.
  task automatic test_default_gestures();
    send_sample(32'd0, 1'b0);
    send_sample(32'd30, 1'b1);
    send_sample(32'd60, 1'b0);
    send_sample(32'd1000, 1'b1);
    send_sample(32'd2000, 1'b1);
    send_sample(32'd4000, 1'b1);
    send_sample(32'd5000, 1'b1);
    send_sample(32'd5100, 1'b0);
    send_sample(32'd5300, 1'b1);
    send_sample(32'd5400, 1'b0);
    send_sample(32'd5420, 1'b1);
    send_sample(32'd5500, 1'b0);
    send_sample(32'd5600, 1'b1);
  endtask

  // Long press and double click measured across the 32-bit wrap of time.
  task automatic test_timestamp_wrap();
    send_sample(32'hFFFF_F000, 1'b0);
    send_sample(32'hFFFF_F800, 1'b1);
    send_sample(32'h0000_0400, 1'b1);
    send_sample(32'h0000_0500, 1'b0);
    send_sample(32'hFFFF_FF00, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0064, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
  endtask

  // Zero debounce and hold time, full window, single color, unused registers.
  task automatic test_register_extremes();
    apply_config(0, 0, 32'hFFFF, 1);
    write_reg(UnusedRegLow, 16'hFFFF);
    write_reg(UnusedRegHigh, 16'h0000);
    enter_select_mode();
    sample_after(32'd1, 1'b1);
    sample_after(32'd1, 1'b1);
    sample_after(32'd1, 1'b0);
    sample_after(32'd1, 1'b1);
    sample_after(32'd1, 1'b0);
  endtask

  // Color count zero wraps the 8-bit index; then a count below the index.
  task automatic test_index_wrap();
    enter_select_mode();
    write_reg(CFG_DBL_WINDOW, 16'd0);
    write_reg(CFG_COLOR_COUNT, 16'd0);
    repeat (259) begin
      sample_after(TsW'($urandom_range(1, 20)), 1'b1);
      if ($urandom_range(0, 2) == 0) begin
        sample_after(TsW'($urandom_range(0, 20)), 1'b1);
      end
      sample_after(TsW'($urandom_range(1, 20)), 1'b0);
    end
    write_reg(CFG_COLOR_COUNT, 16'd2);
    sample_after(32'd5, 1'b1);
    sample_after(32'd5, 1'b0);
    write_reg(CFG_COLOR_COUNT, 16'd255);
    sample_after(32'd5, 1'b1);
    sample_after(32'd5, 1'b0);
  endtask

  // Random gestures under several register settings; the last has no idling.
  task automatic test_random_gestures();
    apply_config(DebounceRst, LongPressRst, DblWindowRst, ColorCountRst);
    random_phase(50);
    apply_config(2, 40, 20, 5);
    random_phase(50);
    apply_config(0, 0, 32'hFFFF, 1);
    random_phase(60);
    apply_config(32'hFFFF, 32'hFFFF, 0, 255);
    random_phase(50);
    apply_config(0, 100, 10, 0);
    random_phase(60);
    apply_config($urandom_range(0, 200), $urandom_range(0, 2000),
                 $urandom_range(0, 600), $urandom_range(0, 255));
    random_phase(60);
    idle_on = 1'b0;
    apply_config(5, 60, 30, 6);
    random_phase(100);
  endtask

  // Result side stalls in random bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (gesture_results_due.size() == 0) begin
        report_mismatch("result with none expected, color_index", out_color_index, 0);
      end else begin
        head_result = gesture_results_due.pop_front();
        if (out_calibrate_request !== head_result.calibrate_request) begin
          report_mismatch("calibrate_request", out_calibrate_request,
                          head_result.calibrate_request);
        end
        if (out_color_saved !== head_result.color_saved) begin
          report_mismatch("color_saved", out_color_saved, head_result.color_saved);
        end
        if (out_color_shown !== head_result.color_shown) begin
          report_mismatch("color_shown", out_color_shown, head_result.color_shown);
        end
        if (out_color_index !== head_result.color_index) begin
          report_mismatch("color_index", out_color_index, head_result.color_index);
        end
        if (out_select_mode !== head_result.select_mode) begin
          report_mismatch("select_mode", out_select_mode, head_result.select_mode);
        end
        results_checked++;
        cal_count   += head_result.calibrate_request;
        saved_count += head_result.color_saved;
        shown_count += head_result.color_shown;
      end
    end
  end

  // Ends the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no item moved for %0d cycles", WatchdogLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_gestures();
    test_timestamp_wrap();
    test_register_extremes();
    test_index_wrap();
    test_random_gestures();
    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    if (gesture_results_due.size() != 0) begin
      report_mismatch("results never delivered", 0, gesture_results_due.size());
    end
    $display("Run covered %0d samples and %0d results: %0d calibrations, %0d saves, %0d advances.",
             items_sent, results_checked, cal_count, saved_count, shown_count);
    $display("%0d register writes, including timing extremes and color counts 0, 1 and 255.",
             cfg_writes);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
